// ===== src/msk_pkg.sv =====
// Shared types and constants for the max stack.
// Used by msk_ctrl, msk_dp and max_stack; no other dependencies.
`timescale 1ns / 1ps

package msk_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int VAL_W     = 32;

	// operation codes
	localparam logic [2:0] OP_PUSH     = 3'd0;
	localparam logic [2:0] OP_POP      = 3'd1;
	localparam logic [2:0] OP_TOP      = 3'd2;
	localparam logic [2:0] OP_PEEK_MAX = 3'd3;
	localparam logic [2:0] OP_POP_MAX  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]              op;
		logic signed [VAL_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic [1:0]              status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_TOP_WAIT,
		S_SCAN,
		S_SCAN_DRAIN,
		S_MAX_DONE,
		S_TRIM,
		S_TRIM_CHK,
		S_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       latch;     // capture incoming item
		logic       push;      // write new live entry, bump occupancy
		logic       rd_top;    // read slot at occupancy-1
		logic       scan_clr;  // restart max scan
		logic       scan_rd;   // read slot at scan index, advance
		logic       kill_best; // mark scan winner dead in place
		logic       occ_dec;   // drop top slot
		logic       trim_rd;   // read slot at occupancy-1 for trimming
		logic       res_rd;    // result <= read data, status ok
		logic       res_best;  // result <= scan winner, status ok
		logic       res_zero;  // result <= zero, status from st
		logic [1:0] st;
		logic       emit;      // load output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] op;
		logic       empty;
		logic       full;
		logic       scan_last;
		logic       best_top;
		logic       rd_live;
		logic       out_free;
	} dp_sts_t;

endpackage

// ===== src/max_stack.sv =====
// Top level of the max stack: sequencer plus datapath.
// Depends on msk_pkg, msk_ctrl and msk_dp.
`timescale 1ns / 1ps

// Stack of signed 32-bit values with push, pop, top, peek-max and pop-max. One item is
// handled at a time; each gives exactly one result. Pop, and pop-max when its winner
// is on top, also trim dead entries off the top. Peek-max and pop-max scan every
// occupied slot through the single read port of the entry memory. Empty or full
// cases return a status code; a push into a full stack is dropped. The next item is
// taken as soon as the previous result sits in the output register, even if that
// result is still stalled.
module max_stack #(
	parameter int DEPTH = msk_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  msk_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output msk_pkg::rsp_t rsp
);
	import msk_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	msk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	msk_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== src/msk_dp.sv =====
// Datapath of the max stack: entry memory, occupancy, scan and result registers.
// Depends on msk_pkg; driven by msk_ctrl.
`timescale 1ns / 1ps

module msk_dp #(
	parameter int DEPTH = msk_pkg::DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  msk_pkg::req_t   req,
	input  logic            rsp_stall,
	output logic            rsp_valid,
	output msk_pkg::rsp_t   rsp,
	input  msk_pkg::dp_cmd_t cmd,
	output msk_pkg::dp_sts_t sts
);
	import msk_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = $clog2(DEPTH + 1);
	localparam logic [OW-1:0] DEPTH_C = OW'(DEPTH);

	// bit VAL_W is the live flag
	logic [VAL_W:0] mem [DEPTH];

	logic [2:0]       op_q;
	logic [VAL_W-1:0] val_q;
	logic [OW-1:0]    occ_q;
	logic [OW-1:0]    occ_m1;
	logic [AW-1:0]    top_idx;
	logic [AW-1:0]    idx_q;
	logic [VAL_W:0]   rd_data_q;
	logic             scan_vld_s1;
	logic [AW-1:0]    scan_idx_s1;
	logic             best_have_q;
	logic [VAL_W-1:0] best_val_q;
	logic [AW-1:0]    best_idx_q;
	logic [VAL_W-1:0] res_val_q;
	logic [1:0]       res_st_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic [AW-1:0]    rd_addr;
	logic             take;

	assign occ_m1  = occ_q - OW'(1);
	assign top_idx = occ_m1[AW-1:0];
	assign rd_addr = cmd.scan_rd ? idx_q : top_idx;

	// live entry takes the lead on >=, so the latest of equal maxima wins
	assign take = rd_data_q[VAL_W] && (!best_have_q ||
		$signed(rd_data_q[VAL_W-1:0]) >= $signed(best_val_q));

	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[occ_q[AW-1:0]] <= {1'b1, val_q};
		else if (cmd.kill_best)
			mem[best_idx_q] <= {1'b0, best_val_q};
		if (cmd.rd_top || cmd.trim_rd || cmd.scan_rd)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			scan_vld_s1 <= 1'b0;
			best_have_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.push)
				occ_q <= occ_q + OW'(1);
			else if (cmd.occ_dec)
				occ_q <= occ_m1;
			scan_vld_s1 <= cmd.scan_rd;
			if (cmd.scan_clr)
				best_have_q <= 1'b0;
			else if (scan_vld_s1 && take)
				best_have_q <= 1'b1;
			if (cmd.emit)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= req.op;
			val_q <= req.push_value;
		end
		if (cmd.scan_clr)
			idx_q <= '0;
		else if (cmd.scan_rd)
			idx_q <= idx_q + AW'(1);
		scan_idx_s1 <= idx_q;
		if (scan_vld_s1 && take) begin
			best_val_q <= rd_data_q[VAL_W-1:0];
			best_idx_q <= scan_idx_s1;
		end
		if (cmd.res_rd) begin
			res_val_q <= rd_data_q[VAL_W-1:0];
			res_st_q  <= ST_OK;
		end else if (cmd.res_best) begin
			res_val_q <= best_val_q;
			res_st_q  <= ST_OK;
		end else if (cmd.res_zero) begin
			res_val_q <= '0;
			res_st_q  <= cmd.st;
		end
		if (cmd.emit)
			rsp_q <= '{result_value: res_val_q, status: res_st_q};
	end

	assign sts.op        = op_q;
	assign sts.empty     = (occ_q == '0);
	assign sts.full      = (occ_q == DEPTH_C);
	assign sts.scan_last = (idx_q == top_idx);
	assign sts.best_top  = (best_idx_q == top_idx);
	assign sts.rd_live   = rd_data_q[VAL_W];
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= DEPTH_C)
		else $error("occupancy beyond depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> occ_q != DEPTH_C)
		else $error("push into full stack");
	a_dec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.occ_dec |-> occ_q != '0)
		else $error("occupancy underflow");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!rsp_valid_q || !rsp_stall))
		else $error("pending result overwritten");

endmodule

// ===== src/msk_ctrl.sv =====
// Sequencer of the max stack: one item at a time through decode, read, scan, trim.
// Depends on msk_pkg; drives msk_dp through dp_cmd_t.
`timescale 1ns / 1ps

module msk_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  msk_pkg::dp_sts_t sts,
	output msk_pkg::dp_cmd_t cmd
);
	import msk_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid)
					state_nx = S_EXEC;
			end
			S_EXEC: begin
				unique case (sts.op)
					OP_POP, OP_TOP: state_nx = sts.empty ? S_FINISH : S_TOP_WAIT;
					OP_PEEK_MAX, OP_POP_MAX: state_nx = sts.empty ? S_FINISH : S_SCAN;
					default: state_nx = S_FINISH;
				endcase
			end
			S_TOP_WAIT: state_nx = (sts.op == OP_POP) ? S_TRIM : S_FINISH;
			S_SCAN: begin
				if (sts.scan_last)
					state_nx = S_SCAN_DRAIN;
			end
			S_SCAN_DRAIN: state_nx = S_MAX_DONE;
			S_MAX_DONE: begin
				if (sts.op == OP_POP_MAX && sts.best_top)
					state_nx = S_TRIM;
				else
					state_nx = S_FINISH;
			end
			S_TRIM: state_nx = sts.empty ? S_FINISH : S_TRIM_CHK;
			S_TRIM_CHK: state_nx = sts.rd_live ? S_FINISH : S_TRIM;
			S_FINISH: begin
				if (sts.out_free)
					state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.latch = req_valid;
			end
			S_EXEC: begin
				unique case (sts.op)
					OP_PUSH: begin
						cmd.res_zero = 1'b1;
						if (sts.full)
							cmd.st = ST_FULL;
						else begin
							cmd.st   = ST_OK;
							cmd.push = 1'b1;
						end
					end
					OP_POP, OP_TOP: begin
						if (sts.empty) begin
							cmd.res_zero = 1'b1;
							cmd.st       = ST_EMPTY;
						end else
							cmd.rd_top = 1'b1;
					end
					OP_PEEK_MAX, OP_POP_MAX: begin
						if (sts.empty) begin
							cmd.res_zero = 1'b1;
							cmd.st       = ST_EMPTY;
						end else
							cmd.scan_clr = 1'b1;
					end
					default: begin
						cmd.res_zero = 1'b1;
						cmd.st       = ST_OK;
					end
				endcase
			end
			S_TOP_WAIT: begin
				cmd.res_rd  = 1'b1;
				cmd.occ_dec = (sts.op == OP_POP);
			end
			S_SCAN: cmd.scan_rd = 1'b1;
			S_SCAN_DRAIN: ;
			S_MAX_DONE: begin
				cmd.res_best = 1'b1;
				if (sts.op == OP_POP_MAX) begin
					// top winner is simply dropped; a deeper one is marked dead
					cmd.occ_dec   = sts.best_top;
					cmd.kill_best = !sts.best_top;
				end
			end
			S_TRIM: cmd.trim_rd = !sts.empty;
			S_TRIM_CHK: cmd.occ_dec = !sts.rd_live;
			S_FINISH: cmd.emit = sts.out_free;
			default: ;
		endcase
	end

	a_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> state_q == S_EXEC)
		else $error("accepted item not decoded");
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_DRAIN) |=> state_q == S_MAX_DONE)
		else $error("scan drain sequence broken");
	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !cmd.emit)
		else $error("result emitted twice");

endmodule
